FILE: rtl/buddy_block_allocator_assert.svh
// Assertion macros shared by the buddy allocator RTL
`ifndef BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_ASSERT_SVH

// condition holds at every edge outside reset
`define BBA_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BBA_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bba_pkg.sv
// Types, codes, defaults and elaboration helpers of the buddy allocator
`default_nettype none
package bba_pkg;

    localparam int PAGE_BITS_DEF   = 12;
    localparam int ORDER_LIMIT_DEF = 25;
    localparam int POOL_PAGES_DEF  = 4096;
    localparam int LEVEL_SLOTS     = 17;

    // configuration register indexes
    localparam logic CFG_POOL_BASE  = 1'b0;
    localparam logic CFG_POOL_BYTES = 1'b1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_INIT  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_FREE   = 2'd2,
        ST_BAD_ADDR  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_A_ORD,
        S_A_RD,
        S_A_TST,
        S_A_SPLIT,
        S_A_DONE,
        S_F_RD,
        S_F_CHK,
        S_F_WALK,
        S_F_BRD,
        S_F_BTST,
        S_F_SET,
        S_I_FIT,
        S_I_SET,
        S_RESP
    } t_state;

    // highest tree level, -1 if no block fits below the order limit
    function automatic int top_level(input int pb, input int ol, input int n);
        int k;
        k = 0;
        if (pb >= ol) begin
            return -1;
        end
        for (int j = 1; j < LEVEL_SLOTS; j++) begin
            if (k + 1 == j && (1 << j) <= n && pb + j < ol) begin
                k = j;
            end
        end
        return k;
    endfunction

    // first free-map entry of level l
    function automatic int level_off(input int n, input int l);
        int s;
        s = 0;
        for (int j = 0; j < LEVEL_SLOTS; j++) begin
            if (j < l) begin
                s = s + (n >> j);
            end
        end
        return s;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module bba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/buddy_block_allocator.sv
// Buddy block allocator top level: sequencer, shared level walker and map memories
//
//  channel | signals                                   | dir | handshake
//  --------+-------------------------------------------+-----+-------------------
//  request | i_operation i_request_size i_block_address | in  | i_valid / o_ready
//  result  | o_granted_address o_granted_order o_status | out | o_valid / i_ready
//  config  | i_cfg_index i_cfg_data                     | in  | i_cfg_we
//
// One item at a time; o_ready is high only while the sequencer is idle.
// Allocate: finds the wanted level, then scans free-map bits from the wanted level up
// (one-bit map memory port), passing up a level at a time, and splits down to the wanted level.
// Free: walks up to the block level, then merges a level for each buddy tested free.
// Initialize and reset clear max(free-map depth, POOL_PAGES) entries (8191 by default);
// only initialize then carves. The result register lets a new item in while the
// previous result waits on i_ready.
`default_nettype none
module buddy_block_allocator #(
    parameter int PAGE_BITS   = bba_pkg::PAGE_BITS_DEF,
    parameter int ORDER_LIMIT = bba_pkg::ORDER_LIMIT_DEF,
    parameter int POOL_PAGES  = bba_pkg::POOL_PAGES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic [31:0] i_request_size,
    input  wire logic [31:0] i_block_address,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_granted_address,
    output logic [4:0]       o_granted_order,
    output logic [1:0]       o_status,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int TOP_I    = bba_pkg::top_level(PAGE_BITS, ORDER_LIMIT, POOL_PAGES);
    localparam bit HAS_TREE = TOP_I >= 0;
    localparam logic [4:0] TOP_L = HAS_TREE ? 5'(TOP_I) : 5'd0;
    localparam int FM_DEPTH = HAS_TREE ? bba_pkg::level_off(POOL_PAGES, TOP_I + 1) : 1;
    localparam int FM_MEM   = FM_DEPTH > 2 ? FM_DEPTH : 2;
    localparam int AW       = $clog2(FM_MEM);
    localparam int PW       = $clog2(POOL_PAGES);
    localparam int CW       = $clog2(POOL_PAGES + 1);
    localparam int OW       = $clog2(2 * POOL_PAGES + 1);
    localparam int CLR_N    = FM_DEPTH > POOL_PAGES ? FM_DEPTH : POOL_PAGES;
    localparam int CLRW     = $clog2(CLR_N + 1);

    bba_pkg::t_state  r_state, n_state;
    bba_pkg::t_op     r_op, n_op;
    logic [31:0]      r_base, r_addr, n_addr;
    logic [24:0]      r_bytes;
    logic [32:0]      r_need, n_need;
    logic [5:0]       r_ord, n_ord;
    logic [4:0]       r_lvl, n_lvl, r_want, n_want;
    logic [OW-1:0]    r_off, n_off;
    logic [CW-1:0]    r_idx, n_idx, r_pos, n_pos, r_rem, n_rem;
    logic [PW-1:0]    r_page, n_page;
    logic [CLRW-1:0]  r_clr, n_clr;
    logic [31:0]      r_res_addr, n_res_addr;
    logic [4:0]       r_res_ord, n_res_ord;
    bba_pkg::t_status r_res_status, n_res_status;
    logic             r_out_valid;
    logic [31:0]      r_out_addr;
    logic [4:0]       r_out_ord;
    bba_pkg::t_status r_out_status;

    logic           fm_we, fm_wdata, fm_rdata;
    logic [OW-1:0]  fm_waddr, fm_raddr;
    logic           am_we;
    logic [PW-1:0]  am_addr;
    logic [4:0]     am_wdata, am_rdata;

    logic           w_accept, w_load;
    logic [CW-1:0]  w_cnt_cur, w_cnt_dn, w_bud, w_step;
    logic [OW-1:0]  w_off_dn;
    logic [31:0]    w_off32;
    logic           w_free_bad, w_ord_bad, w_fit_big, w_clr_last;
    logic [5:0]     w_ord_rel;
    logic [25:0]    w_bpages;
    logic [PW-1:0]  w_alloc_page;
    logic           w_out_ok, w_ord_legal;

    assign o_ready   = (r_state == bba_pkg::S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_load    = (r_state == bba_pkg::S_RESP) && (!r_out_valid || i_ready);

    assign w_cnt_cur = CW'(POOL_PAGES) >> r_lvl;
    assign w_cnt_dn  = CW'(POOL_PAGES) >> (r_lvl - 5'd1);
    assign w_off_dn  = r_off - OW'(w_cnt_dn);
    assign w_bud     = r_idx ^ CW'(1);
    assign w_step    = CW'(1) << r_lvl;
    assign w_fit_big = w_step > r_rem;
    assign w_clr_last = (r_clr == CLRW'(CLR_N - 1));

    assign w_off32    = i_block_address - r_base;
    assign w_free_bad = (w_off32[PAGE_BITS-1:0] != '0)
                     || ((w_off32 >> PAGE_BITS) >= 32'(POOL_PAGES)) || !HAS_TREE;
    assign w_ord_rel  = {1'b0, am_rdata} - 6'(PAGE_BITS);
    assign w_ord_bad  = ({1'b0, am_rdata} < 6'(PAGE_BITS))
                     || ({1'b0, am_rdata} >= 6'(ORDER_LIMIT))
                     || (w_ord_rel > {1'b0, TOP_L});
    assign w_bpages   = {1'b0, r_bytes} >> PAGE_BITS;
    assign w_alloc_page = PW'(r_idx << r_want);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bba_pkg::S_CLR: begin
                if (w_clr_last) begin
                    if (r_op == bba_pkg::OP_INIT) begin
                        n_state = (HAS_TREE && r_rem != '0) ? bba_pkg::S_I_FIT
                                                            : bba_pkg::S_RESP;
                    end else begin
                        n_state = bba_pkg::S_IDLE;
                    end
                end
            end
            bba_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (bba_pkg::t_op'(i_operation))
                        bba_pkg::OP_ALLOC: n_state = bba_pkg::S_A_ORD;
                        bba_pkg::OP_FREE:  n_state = w_free_bad ? bba_pkg::S_RESP
                                                                : bba_pkg::S_F_RD;
                        bba_pkg::OP_INIT:  n_state = bba_pkg::S_CLR;
                        default:           n_state = bba_pkg::S_RESP;
                    endcase
                end
            end
            bba_pkg::S_A_ORD: begin
                if (r_ord >= 6'(ORDER_LIMIT) || !HAS_TREE) begin
                    n_state = bba_pkg::S_RESP;
                end else if (!((33'd1 << r_ord) < r_need)) begin
                    n_state = (r_lvl > TOP_L) ? bba_pkg::S_RESP : bba_pkg::S_A_RD;
                end
            end
            bba_pkg::S_A_RD: begin
                if (r_lvl > TOP_L) begin
                    n_state = bba_pkg::S_RESP;
                end else if (r_idx != w_cnt_cur) begin
                    n_state = bba_pkg::S_A_TST;
                end
            end
            bba_pkg::S_A_TST:   n_state = fm_rdata ? bba_pkg::S_A_SPLIT : bba_pkg::S_A_RD;
            bba_pkg::S_A_SPLIT: begin
                if (r_lvl <= r_want) begin
                    n_state = bba_pkg::S_A_DONE;
                end
            end
            bba_pkg::S_A_DONE:  n_state = bba_pkg::S_RESP;
            bba_pkg::S_F_RD:    n_state = bba_pkg::S_F_CHK;
            bba_pkg::S_F_CHK:   n_state = w_ord_bad ? bba_pkg::S_RESP : bba_pkg::S_F_WALK;
            bba_pkg::S_F_WALK: begin
                if (r_lvl >= r_want) begin
                    n_state = bba_pkg::S_F_BRD;
                end
            end
            bba_pkg::S_F_BRD: begin
                if (r_lvl < TOP_L && w_bud < w_cnt_cur) begin
                    n_state = bba_pkg::S_F_BTST;
                end else begin
                    n_state = bba_pkg::S_F_SET;
                end
            end
            bba_pkg::S_F_BTST:  n_state = fm_rdata ? bba_pkg::S_F_BRD : bba_pkg::S_F_SET;
            bba_pkg::S_F_SET:   n_state = bba_pkg::S_RESP;
            bba_pkg::S_I_FIT: begin
                if (!w_fit_big) begin
                    n_state = bba_pkg::S_I_SET;
                end
            end
            bba_pkg::S_I_SET: begin
                n_state = (r_rem == w_step) ? bba_pkg::S_RESP : bba_pkg::S_I_FIT;
            end
            bba_pkg::S_RESP: begin
                if (w_load) begin
                    n_state = bba_pkg::S_IDLE;
                end
            end
            default: n_state = bba_pkg::S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb begin
        n_op         = r_op;
        n_addr       = r_addr;
        n_need       = r_need;
        n_ord        = r_ord;
        n_lvl        = r_lvl;
        n_want       = r_want;
        n_off        = r_off;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_rem        = r_rem;
        n_page       = r_page;
        n_clr        = r_clr;
        n_res_addr   = r_res_addr;
        n_res_ord    = r_res_ord;
        n_res_status = r_res_status;
        fm_we        = 1'b0;
        fm_wdata     = 1'b0;
        fm_waddr     = r_off + OW'(r_idx);
        fm_raddr     = r_off + OW'(r_idx);
        am_we        = 1'b0;
        am_wdata     = '0;
        am_addr      = r_page;
        case (r_state)
            bba_pkg::S_CLR: begin
                fm_we    = (r_clr < CLRW'(FM_DEPTH));
                fm_waddr = OW'(r_clr);
                am_we    = (r_clr < CLRW'(POOL_PAGES));
                am_addr  = PW'(r_clr);
                n_clr    = r_clr + CLRW'(1);
                if (w_clr_last) begin
                    n_lvl = TOP_L;
                    n_off = OW'(HAS_TREE ? bba_pkg::level_off(POOL_PAGES, TOP_I) : 0);
                    n_pos = '0;
                end
            end
            bba_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_op         = bba_pkg::t_op'(i_operation);
                    n_res_addr   = '0;
                    n_res_ord    = '0;
                    n_res_status = bba_pkg::ST_OK;
                    n_need       = (i_request_size == '0) ? 33'd1 : {1'b0, i_request_size};
                    n_ord        = 6'(PAGE_BITS);
                    n_lvl        = '0;
                    n_off        = '0;
                    n_idx        = '0;
                    n_addr       = i_block_address;
                    n_page       = PW'(w_off32 >> PAGE_BITS);
                    n_clr        = '0;
                    n_rem        = (w_bpages > 26'(POOL_PAGES)) ? CW'(POOL_PAGES)
                                                                : CW'(w_bpages);
                    if (bba_pkg::t_op'(i_operation) == bba_pkg::OP_FREE && w_free_bad) begin
                        n_res_status = bba_pkg::ST_BAD_ADDR;
                    end
                end
            end
            bba_pkg::S_A_ORD: begin
                if (r_ord >= 6'(ORDER_LIMIT) || !HAS_TREE) begin
                    n_res_status = bba_pkg::ST_TOO_LARGE;
                end else if ((33'd1 << r_ord) < r_need) begin
                    n_ord = r_ord + 6'd1;
                    n_off = r_off + OW'(w_cnt_cur);
                    n_lvl = r_lvl + 5'd1;
                end else begin
                    n_want = r_lvl;
                    if (r_lvl > TOP_L) begin
                        n_res_status = bba_pkg::ST_NO_FREE;
                    end
                end
            end
            bba_pkg::S_A_RD: begin
                if (r_lvl > TOP_L) begin
                    n_res_status = bba_pkg::ST_NO_FREE;
                end else if (r_idx == w_cnt_cur) begin
                    n_off = r_off + OW'(w_cnt_cur);
                    n_lvl = r_lvl + 5'd1;
                    n_idx = '0;
                end
            end
            bba_pkg::S_A_TST: begin
                if (fm_rdata) begin
                    fm_we = 1'b1;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            bba_pkg::S_A_SPLIT: begin
                if (r_lvl > r_want) begin
                    fm_we    = 1'b1;
                    fm_wdata = 1'b1;
                    fm_waddr = w_off_dn + ((OW'(r_idx) << 1) | OW'(1));
                    n_off    = w_off_dn;
                    n_lvl    = r_lvl - 5'd1;
                    n_idx    = r_idx << 1;
                end
            end
            bba_pkg::S_A_DONE: begin
                am_we        = 1'b1;
                am_addr      = w_alloc_page;
                am_wdata     = r_ord[4:0];
                n_res_addr   = r_base + (32'(w_alloc_page) << PAGE_BITS);
                n_res_ord    = r_ord[4:0];
                n_res_status = bba_pkg::ST_OK;
            end
            bba_pkg::S_F_CHK: begin
                if (w_ord_bad) begin
                    n_res_status = bba_pkg::ST_BAD_ADDR;
                end else begin
                    am_we  = 1'b1;
                    n_ord  = {1'b0, am_rdata};
                    n_want = w_ord_rel[4:0];
                    n_lvl  = '0;
                    n_off  = '0;
                    n_idx  = CW'(r_page);
                end
            end
            bba_pkg::S_F_WALK: begin
                if (r_lvl < r_want) begin
                    n_off = r_off + OW'(w_cnt_cur);
                    n_lvl = r_lvl + 5'd1;
                    n_idx = r_idx >> 1;
                end
            end
            bba_pkg::S_F_BRD: begin
                fm_raddr = r_off + OW'(w_bud);
            end
            bba_pkg::S_F_BTST: begin
                if (fm_rdata) begin
                    fm_we    = 1'b1;
                    fm_waddr = r_off + OW'(w_bud);
                    n_off    = r_off + OW'(w_cnt_cur);
                    n_lvl    = r_lvl + 5'd1;
                    n_idx    = r_idx >> 1;
                end
            end
            bba_pkg::S_F_SET: begin
                fm_we        = 1'b1;
                fm_wdata     = 1'b1;
                n_res_addr   = r_addr;
                n_res_ord    = r_ord[4:0];
                n_res_status = bba_pkg::ST_OK;
            end
            bba_pkg::S_I_FIT: begin
                if (w_fit_big) begin
                    n_lvl = r_lvl - 5'd1;
                    n_off = w_off_dn;
                end
            end
            bba_pkg::S_I_SET: begin
                fm_we    = 1'b1;
                fm_wdata = 1'b1;
                fm_waddr = r_off + OW'(r_pos >> r_lvl);
                n_pos    = r_pos + w_step;
                n_rem    = r_rem - w_step;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_CLR;
            r_op        <= bba_pkg::OP_ALLOC;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_base      <= '0;
            r_bytes     <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_clr   <= n_clr;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                if (i_cfg_index == bba_pkg::CFG_POOL_BYTES) begin
                    r_bytes <= i_cfg_data[24:0];
                end else begin
                    r_base <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_need       <= n_need;
        r_ord        <= n_ord;
        r_lvl        <= n_lvl;
        r_want       <= n_want;
        r_off        <= n_off;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_rem        <= n_rem;
        r_page       <= n_page;
        r_res_addr   <= n_res_addr;
        r_res_ord    <= n_res_ord;
        r_res_status <= n_res_status;
        if (w_load) begin
            r_out_addr   <= r_res_addr;
            r_out_ord    <= r_res_ord;
            r_out_status <= r_res_status;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_granted_address = r_out_addr;
    assign o_granted_order   = r_out_ord;
    assign o_status          = r_out_status;

    bba_ram #(
        .WIDTH(1),
        .DEPTH(FM_MEM)
    ) u_free_map (
        .i_clk  (i_clk),
        .i_we   (fm_we),
        .i_waddr(fm_waddr[AW-1:0]),
        .i_wdata(fm_wdata),
        .i_raddr(fm_raddr[AW-1:0]),
        .o_rdata(fm_rdata)
    );

    bba_ram #(
        .WIDTH(5),
        .DEPTH(POOL_PAGES)
    ) u_alloc_order (
        .i_clk  (i_clk),
        .i_we   (am_we),
        .i_waddr(am_addr),
        .i_wdata(am_wdata),
        .i_raddr(am_addr),
        .o_rdata(am_rdata)
    );

    assign w_out_ok    = o_valid && o_status == bba_pkg::ST_OK && o_granted_order != 5'd0;
    assign w_ord_legal = 6'(o_granted_order) >= 6'(PAGE_BITS)
                      && 6'(o_granted_order) < 6'(ORDER_LIMIT);

    `include "buddy_block_allocator_assert.svh"

    `BBA_IMPLY(a_scan_in_level, r_state == bba_pkg::S_A_TST, r_idx < w_cnt_cur, "scan past level")
    `BBA_IMPLY(a_split_level, r_state == bba_pkg::S_A_SPLIT, r_lvl <= TOP_L, "split above top")
    `BBA_IMPLY(a_fm_range, fm_we, fm_waddr < OW'(FM_MEM), "free map write out of range")
    `BBA_IMPLY(a_ok_order, w_out_ok, w_ord_legal, "bad granted order")

endmodule
`default_nettype wire
